@@ hw/rtl/cbd_pkg.sv @@
// ============================================================================
// cbd_pkg
// Shared codes and the result record for the console CPU bus decode block.
// ============================================================================
package cbd_pkg;

    // Request kinds.
    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;
    localparam logic [1:0] FN_PAD   = 2'd3;

    // Decoded bus targets.
    localparam logic [2:0] TGT_RAM   = 3'd0;
    localparam logic [2:0] TGT_GFX   = 3'd1;
    localparam logic [2:0] TGT_PAD   = 3'd2;
    localparam logic [2:0] TGT_CART  = 3'd3;
    localparam logic [2:0] TGT_DMA   = 3'd4;
    localparam logic [2:0] TGT_NONE  = 3'd5;

    // Address map.
    localparam logic [15:0] RAM_MASK    = 16'h07FF;
    localparam logic [15:0] RAM_LAST    = 16'h1FFF;
    localparam logic [15:0] GFX_LAST    = 16'h3FFF;
    localparam logic [15:0] GFX_MASK    = 16'h0007;
    localparam logic [15:0] DMA_START   = 16'h4014;
    localparam logic [15:0] PAD0_ADDR   = 16'h4016;
    localparam logic [15:0] PAD1_ADDR   = 16'h4017;
    localparam logic [15:0] CART_FIRST  = 16'h4020;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        ram_sel;       // read_data comes from the RAM read port
        logic [2:0]  target;
        logic [15:0] target_address;
        logic        is_write;
        logic        cpu_step;
        logic        oam_write;
        logic [7:0]  oam_address;
        logic [7:0]  oam_data;
        logic        dma_read;
        logic [15:0] dma_address;
        logic        nmi_out;
        logic        dma_busy;
    } t_result;

    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [7:0]  wdata;
        logic        re;
        logic [15:0] raddr;
    } t_ram_req;

endpackage

@@ hw/rtl/cbd_ram.sv @@
// ============================================================================
// cbd_ram
// Work RAM with one write and one registered read port, and a zero-fill
// sweep after reset.
// ============================================================================
module cbd_ram #(
    parameter int RAM_BYTES = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbd_pkg::t_ram_req    i_req,
    output logic [7:0]           o_rdata,
    output logic                 o_clearing
);
    import cbd_pkg::*;

    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic [7:0]        r_mem [RAM_BYTES];
    logic [7:0]        r_rdata;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == RAM_AW'(RAM_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_req.we) begin
            r_mem[i_req.waddr[RAM_AW-1:0]] <= i_req.wdata;
        end
    end

    // The read register only moves on a RAM read, so it also holds the
    // latest DMA source byte until the core picks it up.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[RAM_AW-1:0]];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

@@ hw/rtl/cbd_core.sv @@
// ============================================================================
// cbd_core
// Address decode, pad shifters, tick divider and sprite DMA sequencing.
// ============================================================================
module cbd_core #(
    parameter int RAM_BYTES  = 2048,
    parameter int CPU_DIVIDE = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_func,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_write_data,
    input  logic                 i_pad_index,
    input  logic [7:0]           i_ext_rdata,
    input  logic                 i_nmi_in,
    input  logic [7:0]           i_ram_rdata,
    output cbd_pkg::t_ram_req    o_ram_req,
    output cbd_pkg::t_result     o_result
);
    import cbd_pkg::*;

    localparam int DIV_W = (CPU_DIVIDE > 1) ? $clog2(CPU_DIVIDE) : 1;

    logic [7:0]       r_pad_btn [2];
    logic [7:0]       n_pad_btn [2];
    logic [7:0]       r_pad_shift [2];
    logic [7:0]       n_pad_shift [2];
    logic [DIV_W-1:0] r_div, n_div;
    logic             r_par, n_par;
    logic             r_running, n_running;
    logic             r_aligned, n_aligned;
    logic [7:0]       r_dma_page, n_dma_page;
    logic [7:0]       r_dma_index, n_dma_index;
    logic [7:0]       r_dma_byte, n_dma_byte;
    logic             r_dma_pend, n_dma_pend;

    logic             do_rd;
    logic             dma_rd;
    logic [15:0]      rd_addr;
    logic [7:0]       rd_val;
    logic [7:0]       eff_byte;
    logic [15:0]      ram_taddr;
    t_result          res;
    t_ram_req         req;

    always_comb begin
        n_pad_btn   = r_pad_btn;
        n_pad_shift = r_pad_shift;
        n_div       = r_div;
        n_par       = r_par;
        n_running   = r_running;
        n_aligned   = r_aligned;
        n_dma_page  = r_dma_page;
        n_dma_index = r_dma_index;
        // A DMA byte read from RAM lands in the RAM read register when the request
        // is taken; fold it into the byte register on the next request.
        eff_byte    = r_dma_pend ? i_ram_rdata : r_dma_byte;
        n_dma_byte  = eff_byte;
        n_dma_pend  = 1'b0;

        res         = '0;
        res.target  = TGT_NONE;
        req         = '0;
        do_rd       = 1'b0;
        dma_rd      = 1'b0;
        rd_addr     = i_address;
        rd_val      = 8'h00;
        ram_taddr   = i_address & 16'(RAM_BYTES - 1) & RAM_MASK;

        case (i_func)
            FN_READ: begin
                do_rd = 1'b1;
            end
            FN_WRITE: begin
                res.is_write       = 1'b1;
                res.target_address = i_address;
                if (i_address <= RAM_LAST) begin
                    res.target         = TGT_RAM;
                    res.target_address = ram_taddr;
                    req.we             = 1'b1;
                    req.waddr          = ram_taddr;
                    req.wdata          = i_write_data;
                end else if (i_address <= GFX_LAST) begin
                    res.target         = TGT_GFX;
                    res.target_address = i_address & GFX_MASK;
                end else if (i_address == DMA_START) begin
                    res.target  = TGT_DMA;
                    n_dma_page  = i_write_data;
                    n_dma_index = 8'h00;
                    n_running   = 1'b1;
                end else if (i_address == PAD0_ADDR || i_address == PAD1_ADDR) begin
                    res.target                 = TGT_PAD;
                    n_pad_shift[i_address[0]]  = r_pad_btn[i_address[0]];
                end else if (i_address >= CART_FIRST) begin
                    res.target = TGT_CART;
                end
            end
            FN_TICK: begin
                if (r_div == '0) begin
                    if (r_running) begin
                        if (r_aligned) begin
                            if (!r_par) begin
                                dma_rd          = 1'b1;
                                do_rd           = 1'b1;
                                rd_addr         = {r_dma_page, r_dma_index};
                                res.dma_read    = 1'b1;
                                res.dma_address = {r_dma_page, r_dma_index};
                            end else begin
                                res.oam_write   = 1'b1;
                                res.oam_address = r_dma_index;
                                res.oam_data    = eff_byte;
                                n_dma_index     = r_dma_index + 8'd1;
                                if (r_dma_index == 8'hFF) begin
                                    n_running = 1'b0;
                                    n_aligned = 1'b0;
                                end
                            end
                        end else if (r_par) begin
                            n_aligned = 1'b1;
                        end
                    end else begin
                        res.cpu_step = 1'b1;
                    end
                end
                if (r_div == DIV_W'(CPU_DIVIDE - 1)) begin
                    n_div = '0;
                end else begin
                    n_div = r_div + 1'b1;
                end
                n_par       = ~r_par;
                res.nmi_out = i_nmi_in;
            end
            FN_PAD: begin
                n_pad_btn[i_pad_index] = i_write_data;
            end
            default: begin
            end
        endcase

        // One bus read decode, shared by CPU reads and DMA source reads.
        if (do_rd) begin
            res.target_address = rd_addr;
            ram_taddr          = rd_addr & 16'(RAM_BYTES - 1) & RAM_MASK;
            if (rd_addr <= RAM_LAST) begin
                res.target         = TGT_RAM;
                res.target_address = ram_taddr;
                res.ram_sel        = 1'b1;
                req.re             = 1'b1;
                req.raddr          = ram_taddr;
            end else if (rd_addr <= GFX_LAST) begin
                res.target         = TGT_GFX;
                res.target_address = rd_addr & GFX_MASK;
                rd_val             = i_ext_rdata;
            end else if (rd_addr == PAD0_ADDR || rd_addr == PAD1_ADDR) begin
                res.target              = TGT_PAD;
                rd_val                  = {7'd0, r_pad_shift[rd_addr[0]][7]};
                n_pad_shift[rd_addr[0]] = {r_pad_shift[rd_addr[0]][6:0], 1'b0};
            end else if (rd_addr >= CART_FIRST) begin
                res.target = TGT_CART;
                rd_val     = i_ext_rdata;
            end else begin
                res.target = TGT_NONE;
            end
            res.read_data = rd_val;
            if (dma_rd) begin
                if (res.ram_sel) begin
                    n_dma_pend = 1'b1;
                end else begin
                    n_dma_byte = rd_val;
                end
            end
        end

        res.dma_busy = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_btn[0]   <= 8'h00;
            r_pad_btn[1]   <= 8'h00;
            r_pad_shift[0] <= 8'h00;
            r_pad_shift[1] <= 8'h00;
            r_div          <= '0;
            r_par          <= 1'b0;
            r_running      <= 1'b0;
            r_aligned      <= 1'b0;
            r_dma_page     <= 8'h00;
            r_dma_index    <= 8'h00;
            r_dma_byte     <= 8'h00;
            r_dma_pend     <= 1'b0;
        end else if (i_accept) begin
            r_pad_btn      <= n_pad_btn;
            r_pad_shift    <= n_pad_shift;
            r_div          <= n_div;
            r_par          <= n_par;
            r_running      <= n_running;
            r_aligned      <= n_aligned;
            r_dma_page     <= n_dma_page;
            r_dma_index    <= n_dma_index;
            r_dma_byte     <= n_dma_byte;
            r_dma_pend     <= n_dma_pend;
        end
    end

    always_comb begin
        o_ram_req    = req;
        o_ram_req.we = req.we & i_accept;
        o_ram_req.re = req.re & i_accept;
    end

    assign o_result = res;

endmodule

@@ hw/rtl/console_cpu_bus_decode_dma_unit.sv @@
// ============================================================================
// console_cpu_bus_decode_dma_unit
// Console CPU bus: address decode, work RAM, pad shifters and sprite DMA.
// ============================================================================
//  channel   handshake                 payload
//  input     i_in_valid / o_in_stall   i_func, i_address, i_write_data,
//                                      i_pad_index, i_ext_rdata, i_nmi_in
//  output    o_out_valid / i_out_stall o_read_data ... o_dma_busy
//
//  The result appears in the output register the cycle after acceptance,
//  and a new request is taken every cycle while o_in_stall is low.
//  RAM read data comes straight from the registered read port of the RAM.
//  After reset the work RAM is zero-filled across all RAM_BYTES (2048) bytes,
//  and o_in_stall stays high during that sweep.
//  A stalled result holds, and input is stalled while it is not taken or during the sweep.
// ============================================================================
module console_cpu_bus_decode_dma_unit #(
    parameter int RAM_BYTES  = 2048,
    parameter int CPU_DIVIDE = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_pad_index,
    input  logic [7:0]  i_ext_rdata,
    input  logic        i_nmi_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [2:0]  o_target,
    output logic [15:0] o_target_address,
    output logic        o_is_write,
    output logic        o_cpu_step,
    output logic        o_oam_write,
    output logic [7:0]  o_oam_address,
    output logic [7:0]  o_oam_data,
    output logic        o_dma_read,
    output logic [15:0] o_dma_address,
    output logic        o_nmi_out,
    output logic        o_dma_busy
);
    import cbd_pkg::*;

    logic     accept;
    logic     clearing;
    logic [7:0] ram_rdata;
    t_ram_req ram_req;
    t_result  result;
    t_result  r_res;
    logic     r_out_valid, n_out_valid;

    assign o_in_stall = clearing | (r_out_valid & i_out_stall);
    assign accept     = i_in_valid & ~o_in_stall;

    cbd_core #(
        .RAM_BYTES  (RAM_BYTES),
        .CPU_DIVIDE (CPU_DIVIDE)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_pad_index  (i_pad_index),
        .i_ext_rdata  (i_ext_rdata),
        .i_nmi_in     (i_nmi_in),
        .i_ram_rdata  (ram_rdata),
        .o_ram_req    (ram_req),
        .o_result     (result)
    );

    cbd_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (ram_req),
        .o_rdata    (ram_rdata),
        .o_clearing (clearing)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_res.ram_sel ? ram_rdata : r_res.read_data;
    assign o_target         = r_res.target;
    assign o_target_address = r_res.target_address;
    assign o_is_write       = r_res.is_write;
    assign o_cpu_step       = r_res.cpu_step;
    assign o_oam_write      = r_res.oam_write;
    assign o_oam_address    = r_res.oam_address;
    assign o_oam_data       = r_res.oam_data;
    assign o_dma_read       = r_res.dma_read;
    assign o_dma_address    = r_res.dma_address;
    assign o_nmi_out        = r_res.nmi_out;
    assign o_dma_busy       = r_res.dma_busy;

endmodule
